/* hw/rtl/bpu_pkg.sv */
package bpu_pkg;

  // Default sizes
  localparam int MAX_WIDTH_DEF     = 4096;
  localparam int MAX_HEIGHT_DEF    = 4096;
  localparam int PALETTE_DEPTH_DEF = 256;

  // Pixel depth codes
  localparam logic [2:0] BPP_1  = 3'd0;
  localparam logic [2:0] BPP_4  = 3'd1;
  localparam logic [2:0] BPP_8  = 3'd2;
  localparam logic [2:0] BPP_16 = 3'd3;
  localparam logic [2:0] BPP_24 = 3'd4;
  localparam logic [2:0] BPP_32 = 3'd5;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_BPP    = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [2:0]  BPP_RESET = BPP_24;
  localparam logic [12:0] DIM_RESET = 13'd1;

  // Sticky flag bit positions
  localparam int FLAG_COLOR      = 0;
  localparam int FLAG_FULL_ALPHA = 1;
  localparam int FLAG_BIN_ALPHA  = 2;

  typedef struct packed {
    logic [2:0]  bpp_code;
    logic [12:0] image_width;
    logic [12:0] image_height;
  } bpu_cfg_t;

  // One accepted request as the decoder sees it
  typedef struct packed {
    logic       action;     // 0 = palette load, 1 = data byte
    logic [7:0] data_byte;
    logic       pal_color;  // palette load that sets the colour flag
  } bpu_item_t;

  // Padding bytes after a row: (-row_bytes) mod 4. Only the low bits of
  // the width matter.
  function automatic logic [1:0] row_pad(logic [2:0] bpp, logic [4:0] w);
    logic [5:0] w7;
    logic [2:0] w1;
    logic [1:0] rb;
    w7 = {1'b0, w} + 6'd7;
    w1 = w[2:0] + 3'd1;
    case (bpp)
      BPP_1:   rb = w7[4:3];
      BPP_4:   rb = w1[2:1];
      BPP_8:   rb = w[1:0];
      BPP_16:  rb = {w[0], 1'b0};
      BPP_24:  rb = w[1:0] + {w[0], 1'b0};
      default: rb = 2'd0;
    endcase
    return 2'd0 - rb;
  endfunction

endpackage

/* hw/rtl/bpu_palette.sv */
module bpu_palette #(
  parameter int DEPTH = bpu_pkg::PALETTE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        wr_en,
  input  logic [7:0]  wr_index,
  input  logic [31:0] wr_data,
  input  logic        rd_en,
  input  logic [7:0]  rd_index_a,
  input  logic [7:0]  rd_index_b,
  output logic [31:0] rd_data_a,
  output logic [31:0] rd_data_b
);

  localparam int AW = $clog2(DEPTH);

  logic [31:0] mem [DEPTH];
  logic [31:0] data_a;
  logic [31:0] data_b;
  logic        oob_a;
  logic        oob_b;

  always_ff @(posedge clk) begin
    if (wr_en && (32'(wr_index) < DEPTH)) begin
      mem[wr_index[AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      data_a <= mem[rd_index_a[AW-1:0]];
      data_b <= mem[rd_index_b[AW-1:0]];
      oob_a  <= (32'(rd_index_a) >= DEPTH);
      oob_b  <= (32'(rd_index_b) >= DEPTH);
    end
  end

  // indexes past the palette read as zero
  assign rd_data_a = oob_a ? 32'd0 : data_a;
  assign rd_data_b = oob_b ? 32'd0 : data_b;

endmodule

/* hw/rtl/bpu_decoder.sv */
module bpu_decoder #(
  parameter int MAX_WIDTH  = bpu_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bpu_pkg::MAX_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  bpu_pkg::bpu_cfg_t  cfg,
  input  logic               restart,
  input  logic               in_accept,
  input  bpu_pkg::bpu_item_t in_item,
  input  logic [31:0]        pal_a,
  input  logic [31:0]        pal_b,
  output logic               st_free,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [71:0]        m_tdata,
  output logic               m_tlast
);

  import bpu_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);

  // item stage
  logic      st_valid;
  bpu_item_t st_item;
  logic [2:0] k;
  logic [2:0] k_next;

  // stream position
  logic [CW-1:0] column_count, cc_next;
  logic [RW-1:0] rows_done, rd_next;
  logic [1:0]    byte_phase, phase_next;
  logic [23:0]   partial, part_next;
  logic [1:0]    pad_left, pad_next;
  logic [2:0]    flags, flags_next;
  logic          image_done, done_next;

  logic [CW-1:0] w_eff, col_inc;
  logic [RW-1:0] h_eff, rows_inc, row_full;
  logic          row_end, img_end;

  logic        go, out_free, emit, retire, last_item, last_img;
  logic [7:0]  pr, pg, pb, pa, pidx, mono;
  logic        indexed;
  logic [31:0] ent;
  logic [15:0] s16;
  logic [1:0]  need;
  logic        collect;
  logic [2:0]  pix_flags;
  logic [7:0]  d;

  // output register
  logic [7:0]  o_r, o_g, o_b, o_a, o_idx;
  logic [11:0] o_col, o_row;
  logic [2:0]  o_flags;
  logic        o_last_img, o_last_item;

  assign d        = st_item.data_byte;
  assign out_free = !m_tvalid || m_tready;
  assign go       = st_valid && out_free;
  assign st_free  = !st_valid || retire;

  always_comb begin
    if (cfg.image_width == 13'd0) begin
      w_eff = CW'(1);
    end else if (32'(cfg.image_width) > MAX_WIDTH) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(cfg.image_width);
    end
    if (cfg.image_height == 13'd0) begin
      h_eff = RW'(1);
    end else if (32'(cfg.image_height) > MAX_HEIGHT) begin
      h_eff = RW'(MAX_HEIGHT);
    end else begin
      h_eff = RW'(cfg.image_height);
    end
  end

  assign col_inc  = column_count + CW'(1);
  assign rows_inc = rows_done + RW'(1);
  assign row_full = h_eff - RW'(1) - rows_done;
  assign row_end  = (col_inc >= w_eff);
  assign img_end  = row_end && (rows_inc >= h_eff);

  // pixel source for the current step
  always_comb begin
    pr      = 8'h00;
    pg      = 8'h00;
    pb      = 8'h00;
    pa      = 8'hFF;
    pidx    = 8'h00;
    indexed = 1'b0;
    ent     = 32'd0;
    mono    = d[3'd7 - k] ? 8'hFF : 8'h00;
    s16     = {d, partial[7:0]};
    case (cfg.bpp_code)
      BPP_1: begin
        pr = mono;
        pg = mono;
        pb = mono;
        pa = 8'h00;
      end
      BPP_4: begin
        ent     = k[0] ? pal_b : pal_a;
        pidx    = k[0] ? {4'h0, d[3:0]} : {4'h0, d[7:4]};
        indexed = 1'b1;
      end
      BPP_8: begin
        ent     = pal_a;
        pidx    = d;
        indexed = 1'b1;
      end
      BPP_16: begin
        pr = {s16[14:10], 3'b000};
        pg = {s16[9:5], 3'b000};
        pb = {s16[4:0], 3'b000};
      end
      BPP_24: begin
        pr = d;
        pg = partial[15:8];
        pb = partial[7:0];
      end
      BPP_32: begin
        pr = partial[23:16];
        pg = partial[15:8];
        pb = partial[7:0];
        pa = d;
      end
      default: begin
        pa = 8'hFF;
      end
    endcase
    if (indexed) begin
      pr = ent[23:16];
      pg = ent[15:8];
      pb = ent[7:0];
      pa = ent[31:24];
    end
  end

  always_comb begin
    pix_flags = flags;
    if (!indexed && ((pr != pg) || (pg != pb))) begin
      pix_flags[FLAG_COLOR] = 1'b1;
    end
    if (pa != 8'hFF) begin
      if (pa != 8'h00) begin
        pix_flags[FLAG_FULL_ALPHA] = 1'b1;
        pix_flags[FLAG_BIN_ALPHA]  = 1'b0;
      end else if (!flags[FLAG_FULL_ALPHA]) begin
        pix_flags[FLAG_BIN_ALPHA] = 1'b1;
      end
    end
  end

  // bytes collected before a direct-colour pixel is complete
  always_comb begin
    case (cfg.bpp_code)
      BPP_16:  need = 2'd1;
      BPP_24:  need = 2'd2;
      BPP_32:  need = 2'd3;
      default: need = 2'd0;
    endcase
  end
  assign collect = (need != 2'd0) && (byte_phase < need);

  always_comb begin
    cc_next    = column_count;
    rd_next    = rows_done;
    phase_next = byte_phase;
    part_next  = partial;
    pad_next   = pad_left;
    flags_next = flags;
    done_next  = image_done;
    k_next     = k;
    emit       = 1'b0;
    retire     = 1'b0;
    last_item  = 1'b0;
    last_img   = 1'b0;
    if (go) begin
      if (!st_item.action) begin
        retire = 1'b1;
        if (st_item.pal_color) begin
          flags_next[FLAG_COLOR] = 1'b1;
        end
      end else if (image_done || (cfg.bpp_code > BPP_32)) begin
        retire = 1'b1;
      end else if (pad_left != 2'd0) begin
        pad_next = pad_left - 2'd1;
        retire   = 1'b1;
      end else if (collect) begin
        case (byte_phase)
          2'd0:    part_next[7:0]   = d;
          2'd1:    part_next[15:8]  = d;
          default: part_next[23:16] = d;
        endcase
        phase_next = byte_phase + 2'd1;
        retire     = 1'b1;
      end else begin
        emit       = 1'b1;
        flags_next = pix_flags;
        phase_next = 2'd0;
        if (row_end) begin
          cc_next  = '0;
          rd_next  = rows_inc;
          pad_next = row_pad(cfg.bpp_code, w_eff[4:0]);
          if (img_end) begin
            done_next = 1'b1;
            last_img  = 1'b1;
          end
        end else begin
          cc_next = col_inc;
        end
        case (cfg.bpp_code)
          BPP_1:   last_item = row_end || (k == 3'd7);
          BPP_4:   last_item = row_end || k[0];
          default: last_item = 1'b1;
        endcase
        retire = last_item;
        if (!last_item) begin
          k_next = k + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (in_accept) begin
      st_valid <= 1'b1;
    end else if (retire) begin
      st_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      st_item <= in_item;
      k       <= 3'd0;
    end else if (go) begin
      k <= k_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else begin
      flags <= flags_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      column_count <= '0;
      rows_done    <= '0;
      byte_phase   <= '0;
      partial      <= '0;
      pad_left     <= '0;
      image_done   <= 1'b0;
    end else begin
      column_count <= cc_next;
      rows_done    <= rd_next;
      byte_phase   <= phase_next;
      partial      <= part_next;
      pad_left     <= pad_next;
      image_done   <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_r         <= pr;
      o_g         <= pg;
      o_b         <= pb;
      o_a         <= pa;
      o_idx       <= indexed ? pidx : 8'h00;
      o_col       <= 12'(column_count);
      o_row       <= 12'(row_full);
      o_flags     <= pix_flags;
      o_last_img  <= last_img;
      o_last_item <= last_item;
    end
  end

  assign m_tdata = {4'b0000, o_last_img, o_flags[FLAG_BIN_ALPHA], o_flags[FLAG_FULL_ALPHA],
                    o_flags[FLAG_COLOR], o_row, o_col, o_idx, o_a, o_b, o_g, o_r};
  assign m_tlast = o_last_item;

endmodule

/* hw/rtl/bmp_pixel_unpacker.sv */
// Unpacker for the pixel area of an uncompressed BMP at 1, 4, 8, 16, 24 or
// 32 bits per pixel. Load palette entries first (tuser = 0), then send the
// pixel area one byte per request (tuser = 1), row padding included; the
// padding is skipped here. The first file row comes out as out_row =
// height - 1. Each pixel leaves as RGBA with its column and row; 4 and 8 bit
// modes also give the palette index, 1-bit pixels are black or white with
// alpha 0. Sticky colour and alpha flags ride along with every pixel. A write
// to one of the three defined registers restarts the stream at the first file
// row and keeps the palette and flags. Once the last pixel of the image is out,
// further data bytes are dropped until the next such write or reset.
// Rate: one request per cycle for palette loads, padding, and 8/16/24/32 bit
// data while the output is not stalled. A data byte gives at most one pixel per
// cycle from the output register, so a 4-bit byte holds the input until both
// its pixels are emitted and a 1-bit byte until all of its pixels are. A
// request passes the palette read register, then the output register.
module bmp_pixel_unpacker #(
  parameter int MAX_WIDTH     = bpu_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT    = bpu_pkg::MAX_HEIGHT_DEF,
  parameter int PALETTE_DEPTH = bpu_pkg::PALETTE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // requests in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // palette_index[7:0], palette_entry[39:8], data_byte[47:40]
  input  logic        s_tuser,   // action
  // pixels out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // red[7:0], green[15:8], blue[23:16], alpha[31:24],
                                 // color_index[39:32], out_column[51:40], out_row[63:52],
                                 // has_color[64], has_full_alpha[65],
                                 // has_binary_alpha[66], last_of_image[67], zero[71:68]
  output logic        m_tlast    // last_of_item
);

  import bpu_pkg::*;

  bpu_cfg_t   cfg;
  bpu_item_t  in_item;
  logic       cfg_we;
  logic       restart;
  logic       in_accept;
  logic       st_free;
  logic [7:0] pal_index;
  logic [31:0] pal_entry;
  logic [7:0] data_byte;
  logic [7:0] rd_index_a;
  logic [31:0] pal_a;
  logic [31:0] pal_b;
  logic       entry_color;

  // ---------------------------------------------------------------- registers
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  // only the three defined registers restart the stream
  assign restart = cfg_we && ((paddr[3:2] == REG_BPP) || (paddr[3:2] == REG_WIDTH) ||
                              (paddr[3:2] == REG_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bpp_code     <= BPP_RESET;
      cfg.image_width  <= DIM_RESET;
      cfg.image_height <= DIM_RESET;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_BPP:    cfg.bpp_code     <= pwdata[2:0];
        REG_WIDTH:  cfg.image_width  <= pwdata[12:0];
        REG_HEIGHT: cfg.image_height <= pwdata[12:0];
        default:    cfg.bpp_code     <= cfg.bpp_code;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_BPP:    prdata = {29'd0, cfg.bpp_code};
      REG_WIDTH:  prdata = {19'd0, cfg.image_width};
      REG_HEIGHT: prdata = {19'd0, cfg.image_height};
      default:    prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------- input side
  assign pal_index = s_tdata[7:0];
  assign pal_entry = s_tdata[39:8];
  assign data_byte = s_tdata[47:40];

  // the decoder stage takes a new request whenever it is empty or its current one retires
  assign s_tready  = st_free;
  assign in_accept = s_tvalid && s_tready;

  // a palette load only counts toward the colour flag in indexed modes
  assign entry_color = ((pal_entry[23:16] != pal_entry[15:8]) ||
                        (pal_entry[15:8] != pal_entry[7:0])) &&
                       ((cfg.bpp_code == BPP_4) || (cfg.bpp_code == BPP_8)) &&
                       (32'(pal_index) < PALETTE_DEPTH);

  assign in_item.action    = s_tuser;
  assign in_item.data_byte = data_byte;
  assign in_item.pal_color = entry_color;

  // palette is written as the load request is taken, so any later byte sees
  // it; both nibbles of a 4-bit byte are looked up at once
  assign rd_index_a = (cfg.bpp_code == BPP_4) ? {4'h0, data_byte[7:4]} : data_byte;

  bpu_palette #(
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk        (clk),
    .wr_en      (in_accept && !s_tuser),
    .wr_index   (pal_index),
    .wr_data    (pal_entry),
    .rd_en      (in_accept && s_tuser),
    .rd_index_a (rd_index_a),
    .rd_index_b ({4'h0, data_byte[3:0]}),
    .rd_data_a  (pal_a),
    .rd_data_b  (pal_b)
  );

  // ---------------------------------------------------------------- decoder
  bpu_decoder #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_decoder (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .restart   (restart),
    .in_accept (in_accept),
    .in_item   (in_item),
    .pal_a     (pal_a),
    .pal_b     (pal_b),
    .st_free   (st_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

/* tb/bmp_pixel_unpacker_checker.sv */
`timescale 1ns / 100ps

module bmp_pixel_unpacker_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,   // palette_index[7:0], palette_entry[39:8], data_byte[47:40]
  input  logic        s_tuser,   // action
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [71:0] m_tdata,   // red, green, blue, alpha, color_index, out_column,
                                 // out_row, has_color, has_full_alpha,
                                 // has_binary_alpha, last_of_image
  input  logic        m_tlast,   // last_of_item
  output int          mismatches,
  output int          outstanding,
  output int          pixels_seen
);

  import bpu_pkg::*;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  cindex;
    logic [11:0] column;
    logic [11:0] row;
    logic        colored;
    logic        full_alpha;
    logic        bin_alpha;
    logic        item_end;
    logic        image_end;
  } pixel_t;

  // shadow of the decoder state
  logic [2:0]  bpp;
  logic [12:0] wid_reg;
  logic [12:0] hgt_reg;
  logic [31:0] palette [256];
  logic [23:0] partial;
  logic [2:0]  flags;
  logic        done;
  int          col;
  int          rows_out;
  int          phase;
  int          pad;

  pixel_t      pixel_q[$];
  pixel_t      burst [8];
  int          burst_n;
  int          errors = 0;
  int          pixel_no = 0;
  pixel_t      got;
  pixel_t      want;
  logic        bad;

  function automatic int clamp_dim(logic [12:0] raw, int lim);
    if (raw == 13'd0) return 1;
    if (raw > lim) return lim;
    return int'(raw);
  endfunction

  function automatic int bits_of(logic [2:0] code);
    case (code)
      BPP_1:   return 1;
      BPP_4:   return 4;
      BPP_8:   return 8;
      BPP_16:  return 16;
      BPP_24:  return 24;
      default: return 32;
    endcase
  endfunction

  function automatic void rewind();
    col = 0;
    rows_out = 0;
    phase = 0;
    partial = '0;
    pad = 0;
    done = 1'b0;
  endfunction

  function automatic string show(pixel_t p);
    return $sformatf("rgba %02h %02h %02h %02h idx %0d col %0d row %0d flags %b%b%b last %b/%b",
                     p.red, p.green, p.blue, p.alpha, p.cindex, p.column, p.row,
                     p.bin_alpha, p.full_alpha, p.colored, p.item_end, p.image_end);
  endfunction

  // one pixel into the burst buffer; returns 1 when it closes a row
  function automatic logic put_pixel(input logic [7:0] r, input logic [7:0] g,
                                     input logic [7:0] b, input logic [7:0] a,
                                     input logic [7:0] cidx, input logic indexed);
    int     w;
    int     h;
    int     rb;
    int     row_now;
    pixel_t p;
    logic   row_end;
    w = clamp_dim(wid_reg, MAX_WIDTH_DEF);
    h = clamp_dim(hgt_reg, MAX_HEIGHT_DEF);
    row_now = h - 1 - rows_out;
    p.column = col[11:0];
    p.row = row_now[11:0];
    if (!indexed && (r != g || g != b)) flags[FLAG_COLOR] = 1'b1;
    if (a != 8'hFF) begin
      if (a != 8'h00) begin
        flags[FLAG_FULL_ALPHA] = 1'b1;
        flags[FLAG_BIN_ALPHA] = 1'b0;
      end else if (!flags[FLAG_FULL_ALPHA]) begin
        flags[FLAG_BIN_ALPHA] = 1'b1;
      end
    end
    row_end = 1'b0;
    p.image_end = 1'b0;
    col++;
    if (col >= w) begin
      rb = (w * bits_of(bpp) + 7) / 8;
      col = 0;
      rows_out++;
      pad = (4 - (rb % 4)) % 4;
      row_end = 1'b1;
      if (rows_out >= h) begin
        done = 1'b1;
        p.image_end = 1'b1;
      end
    end
    p.red = r;
    p.green = g;
    p.blue = b;
    p.alpha = a;
    p.cindex = indexed ? cidx : 8'h00;
    p.colored = flags[FLAG_COLOR];
    p.full_alpha = flags[FLAG_FULL_ALPHA];
    p.bin_alpha = flags[FLAG_BIN_ALPHA];
    p.item_end = 1'b0;
    burst[burst_n] = p;
    burst_n++;
    return row_end;
  endfunction

  function automatic logic put_indexed(input logic [7:0] idx);
    logic [31:0] e;
    e = palette[idx];
    return put_pixel(e[23:16], e[15:8], e[7:0], e[31:24], idx, 1'b1);
  endfunction

  task automatic decode_request(input logic is_data, input logic [7:0] pidx,
                                input logic [31:0] pent, input logic [7:0] db);
    int          k;
    int          need;
    logic        stop;
    logic [7:0]  v;
    logic [15:0] s;
    burst_n = 0;
    if (!is_data) begin
      palette[pidx] = pent;
      if ((bpp == BPP_4 || bpp == BPP_8) &&
          (pent[23:16] != pent[15:8] || pent[15:8] != pent[7:0]))
        flags[FLAG_COLOR] = 1'b1;
    end else if (!done && bpp <= BPP_32) begin
      if (pad > 0) begin
        pad--;
      end else begin
        case (bpp)
          BPP_1: begin
            stop = 1'b0;
            k = 0;
            while (!stop && k < 8) begin
              v = db[7-k] ? 8'hFF : 8'h00;
              stop = put_pixel(v, v, v, 8'h00, 8'h00, 1'b0);
              k++;
            end
          end
          BPP_4: begin
            stop = put_indexed({4'h0, db[7:4]});
            if (!stop) stop = put_indexed({4'h0, db[3:0]});
          end
          BPP_8: stop = put_indexed(db);
          default: begin
            need = (bpp == BPP_16) ? 1 : (bpp == BPP_24) ? 2 : 3;
            if (phase < need) begin
              partial[8*phase +: 8] = db;
              phase++;
            end else begin
              phase = 0;
              if (bpp == BPP_16) begin
                s = {db, partial[7:0]};
                stop = put_pixel({s[14:10], 3'b000}, {s[9:5], 3'b000}, {s[4:0], 3'b000},
                                 8'hFF, 8'h00, 1'b0);
              end else if (bpp == BPP_24) begin
                stop = put_pixel(db, partial[15:8], partial[7:0], 8'hFF, 8'h00, 1'b0);
              end else begin
                stop = put_pixel(partial[23:16], partial[15:8], partial[7:0], db,
                                 8'h00, 1'b0);
              end
            end
          end
        endcase
      end
    end
    if (burst_n > 0) burst[burst_n-1].item_end = 1'b1;
    for (k = 0; k < burst_n; k++) pixel_q.push_back(burst[k]);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      bpp = BPP_RESET;
      wid_reg = DIM_RESET;
      hgt_reg = DIM_RESET;
      flags = '0;
      rewind();
      pixel_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.red = m_tdata[7:0];
        got.green = m_tdata[15:8];
        got.blue = m_tdata[23:16];
        got.alpha = m_tdata[31:24];
        got.cindex = m_tdata[39:32];
        got.column = m_tdata[51:40];
        got.row = m_tdata[63:52];
        got.colored = m_tdata[64];
        got.full_alpha = m_tdata[65];
        got.bin_alpha = m_tdata[66];
        got.image_end = m_tdata[67];
        got.item_end = m_tlast;
        pixel_no++;
        if (pixel_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("pixel %0d with nothing expected: %s", pixel_no, show(got));
        end else begin
          want = pixel_q.pop_front();
          bad = (got.red !== want.red) || (got.green !== want.green) ||
                (got.blue !== want.blue) || (got.alpha !== want.alpha) ||
                (got.cindex !== want.cindex) || (got.column !== want.column) ||
                (got.row !== want.row) || (got.colored !== want.colored) ||
                (got.full_alpha !== want.full_alpha) || (got.bin_alpha !== want.bin_alpha) ||
                (got.item_end !== want.item_end) || (got.image_end !== want.image_end);
          if (bad) begin
            errors++;
            if (errors <= 10)
              $display("pixel %0d wrong\n  expected %s\n  actual   %s",
                       pixel_no, show(want), show(got));
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_BPP: begin
            bpp = pwdata[2:0];
            rewind();
          end
          REG_WIDTH: begin
            wid_reg = pwdata[12:0];
            rewind();
          end
          REG_HEIGHT: begin
            hgt_reg = pwdata[12:0];
            rewind();
          end
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        decode_request(s_tuser, s_tdata[7:0], s_tdata[39:8], s_tdata[47:40]);
    end
    mismatches <= errors;
    outstanding <= pixel_q.size();
    pixels_seen <= pixel_no;
  end

endmodule

/* tb/bmp_pixel_unpacker_test.sv */
`timescale 1ns / 100ps

module bmp_pixel_unpacker_test;

  import bpu_pkg::*;

  // action carried on s_tuser
  localparam logic ACT_PALETTE = 1'b0;
  localparam logic ACT_DATA    = 1'b1;

  localparam int RANDOM_ITEMS = 380;
  localparam int HOLD_PHASE   = 3;    // phase where the receiver backs off hard

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // palette_index[7:0], palette_entry[39:8], data_byte[47:40]
  logic        s_tuser;   // action
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;   // red[7:0], green[15:8], blue[23:16], alpha[31:24],
                          // color_index[39:32], out_column[51:40], out_row[63:52],
                          // has_color[64], has_full_alpha[65], has_binary_alpha[66],
                          // last_of_image[67]
  logic        m_tlast;   // last_of_item

  int mismatches;
  int outstanding;
  int pixels_seen;

  // stimulus bookkeeping
  int          burst_left = 0;
  int          requests_sent = 0;
  int          reg_writes = 0;
  bit          long_hold = 1'b0;   // raised by the stimulus, cleared by the receiver
  logic [2:0]  cur_bpp;
  int          img_w;
  int          img_h;
  bit          pal_loaded [256];
  int          loaded_idx[$];      // palette entries safe to reference
  int          loaded_low[$];      // the subset usable as 4-bit nibbles

  bmp_pixel_unpacker uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  bmp_pixel_unpacker_checker chk (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .mismatches(mismatches), .outstanding(outstanding), .pixels_seen(pixels_seen)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Timed out with %0d pixels still expected", outstanding);
    $display("Mismatches found");
    $finish;
  end

  // Receiver: switches between stall styles, each kept for a random span. On request
  // it holds m_tready low for a long stretch so the pipeline backs up into
  // the request side.
  initial begin : receiver
    int style;
    int span;
    int hold;
    int beat;
    span = 0;
    style = 0;
    beat = 0;
    forever begin
      if (long_hold) begin
        m_tready <= 1'b0;
        hold = 0;
        while (hold < 200) begin
          @(posedge clk);
          hold++;
        end
        long_hold = 1'b0;
      end else begin
        if (span == 0) begin
          style = $urandom_range(0, 3);
          span = $urandom_range(20, 80);
        end
        span--;
        beat++;
        case (style)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= (beat % 5 != 0) && (beat % 7 != 3);
        endcase
        @(posedge clk);
      end
    end
  end

  function automatic int clamp_dim(int raw, int lim);
    return (raw == 0) ? 1 : (raw > lim) ? lim : raw;
  endfunction

  // One request on the slave side. Bursts of random length with random gaps;
  // tvalid stays high across back-to-back requests inside a burst.
  task automatic push_request(input logic act, input logic [7:0] pidx,
                              input logic [31:0] pent, input logic [7:0] db);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= {db, pent, pidx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    requests_sent++;
  endtask

  task automatic load_entry(input int idx, input logic [31:0] entry);
    push_request(ACT_PALETTE, idx[7:0], entry, 8'($urandom_range(0, 255)));
    if (!pal_loaded[idx]) begin
      pal_loaded[idx] = 1'b1;
      loaded_idx.push_back(idx);
      if (idx < 16) loaded_low.push_back(idx);
    end
  endtask

  // Data byte; in indexed modes every referenced entry must already be loaded.
  // Unused fields carry random noise.
  task automatic send_byte(input logic [7:0] db);
    logic [7:0] b;
    b = db;
    if (cur_bpp == BPP_8 && !pal_loaded[b])
      b = 8'(loaded_idx[$urandom_range(0, loaded_idx.size() - 1)]);
    if (cur_bpp == BPP_4) begin
      if (!pal_loaded[b[7:4]])
        b[7:4] = 4'(loaded_low[$urandom_range(0, loaded_low.size() - 1)]);
      if (!pal_loaded[b[3:0]])
        b[3:0] = 4'(loaded_low[$urandom_range(0, loaded_low.size() - 1)]);
    end
    push_request(ACT_DATA, 8'($urandom_range(0, 255)), $urandom, b);
  endtask

  // Registers change only with the block idle: stop offering requests, let
  // every expected pixel drain, then allow the pipeline latency to settle.
  task automatic drain_stream();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one write; psel stays up so writes can follow back to back
  task automatic set_reg(input logic [1:0] idx, input int val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    reg_writes++;
  endtask

  // writes all three registers, starting at a random one
  task automatic set_format(input logic [2:0] bpp, input int w, input int h);
    int first;
    int k;
    drain_stream();
    first = $urandom_range(0, 2);
    for (k = 0; k < 3; k++) begin
      case ((first + k) % 3)
        0: set_reg(REG_BPP, int'(bpp));
        1: set_reg(REG_WIDTH, w);
        default: set_reg(REG_HEIGHT, h);
      endcase
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cur_bpp = bpp;
    img_w = clamp_dim(w, MAX_WIDTH_DEF);
    img_h = clamp_dim(h, MAX_HEIGHT_DEF);
  endtask

  initial begin : stimulus
    int          phase_no;
    int          fed;
    int          nbytes;
    int          extra;
    int          bits;
    int          k;
    int          n;
    int          idx;
    int          w_raw;
    int          h_raw;
    logic [2:0]  bpp;
    logic [7:0]  a;
    logic [7:0]  grey;
    logic [31:0] entry;
    logic [7:0]  db;
    logic        truncated;

    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    s_tvalid <= 1'b0;
    s_tuser <= ACT_PALETTE;
    s_tdata <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part ----
    // Flags are sticky for the whole run, so grey and opaque cases come first,
    // then alpha 0, then partial alpha and colour.
    cur_bpp = BPP_RESET;
    img_w = 1;
    img_h = 1;
    // reset format, 24 bit 1x1: one grey pixel, then a byte past the image end
    send_byte(8'h80);
    send_byte(8'h80);
    send_byte(8'h80);
    send_byte(8'h11);

    // 8 bit, index extremes; 3 bytes per row leaves one pad byte
    set_format(BPP_8, 3, 1);
    load_entry(0, 32'hFF000000);
    load_entry(255, 32'h00FFFFFF);    // white, alpha 0
    load_entry(8'h80, 32'hFF7F7F7F);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'hAA);

    // 1 bit, width 9: the row ends in the second byte, rest of it dropped
    set_format(BPP_1, 9, 1);
    send_byte(8'hA5);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);

    // 4 bit, odd width: second nibble of the last byte is dropped.
    // The coloured, half-transparent entry sets colour from the palette side.
    set_format(BPP_4, 3, 1);
    load_entry(15, 32'h80402010);
    send_byte(8'hF0);
    send_byte(8'h0F);
    send_byte(8'h55);
    send_byte(8'h55);

    // 16 bit with both sizes over range: clamps to 4096, first row is 4095
    set_format(BPP_16, 8191, 8191);
    send_byte(8'hFF);
    send_byte(8'h7F);
    send_byte(8'h00);
    send_byte(8'h80);

    // 32 bit with zero sizes (clamp to 1), partial alpha from the data
    set_format(BPP_32, 0, 0);
    send_byte(8'h01);
    send_byte(8'h02);
    send_byte(8'h03);
    send_byte(8'h04);

    // unsupported depth codes: data is dropped
    set_format(3'd6, 4, 1);
    send_byte(8'h3C);
    set_format(3'd7, 4, 1);
    send_byte(8'hC3);

    // ---- random part ----
    // Mostly whole images at small sizes with random content; some cut short,
    // some followed by stray bytes, a few with huge sizes that are abandoned
    // early through a register write.
    fed = 0;
    phase_no = 0;
    while (fed < RANDOM_ITEMS) begin
      phase_no++;
      bpp = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) :
                                           3'($urandom_range(0, 5));
      case ($urandom_range(0, 9))
        0: w_raw = ($urandom_range(0, 1) != 0) ? 4096 : 8191;
        1: w_raw = 0;
        default: w_raw = $urandom_range(1, 10);
      endcase
      case ($urandom_range(0, 9))
        0: h_raw = ($urandom_range(0, 1) != 0) ? 4096 : 8191;
        1: h_raw = 0;
        default: h_raw = $urandom_range(1, 3);
      endcase
      if (phase_no == HOLD_PHASE) begin
        bpp = BPP_1;
        w_raw = 16;
        h_raw = 2;
      end
      set_format(bpp, w_raw, h_raw);
      if (phase_no == HOLD_PHASE) long_hold = 1'b1;

      // fresh palette entries ahead of indexed images, and sometimes ahead of others
      if (cur_bpp == BPP_4 || cur_bpp == BPP_8 || $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++) begin
          idx = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 15) : $urandom_range(0, 255);
          case ($urandom_range(0, 2))
            0: a = 8'h00;
            1: a = 8'hFF;
            default: a = 8'($urandom_range(0, 255));
          endcase
          grey = 8'($urandom_range(0, 255));
          entry = ($urandom_range(0, 2) == 0) ? {a, grey, grey, grey} : {a, 24'($urandom)};
          load_entry(idx, entry);
          fed++;
        end
      end

      truncated = 1'b0;
      extra = 0;
      if (cur_bpp > BPP_32) begin
        nbytes = 0;
        extra = $urandom_range(2, 5);
      end else if (img_w > 64 || img_h > 8) begin
        nbytes = $urandom_range(8, 40);
      end else begin
        case (cur_bpp)
          BPP_1:   bits = 1;
          BPP_4:   bits = 4;
          BPP_8:   bits = 8;
          BPP_16:  bits = 16;
          BPP_24:  bits = 24;
          default: bits = 32;
        endcase
        nbytes = ((img_w * bits + 31) / 32) * 4 * img_h;
        if ($urandom_range(0, 6) == 0) begin
          nbytes = $urandom_range(1, nbytes);
          truncated = 1'b1;
        end
        if (!truncated && $urandom_range(0, 4) == 0) extra = $urandom_range(1, 3);
      end

      for (k = 0; k < nbytes + extra; k++) begin
        // occasional palette write in the middle of the pixel stream
        if (k < nbytes && $urandom_range(0, 19) == 0) begin
          load_entry($urandom_range(0, 255), $urandom);
          fed++;
        end
        case ($urandom_range(0, 7))
          0: db = 8'h00;
          1: db = 8'hFF;
          default: db = 8'($urandom_range(0, 255));
        endcase
        send_byte(db);
        if (k < nbytes) fed++;
      end
    end

    // ---- wind down ----
    drain_stream();
    repeat (10) @(posedge clk);
    $display("Covered %0d requests and %0d register writes, %0d pixels compared",
             requests_sent, reg_writes, pixels_seen);
    $display("All depth codes, clamped sizes, row padding, palette reloads, long output stall");
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/bpu_pkg.sv
hw/rtl/bpu_palette.sv
hw/rtl/bpu_decoder.sv
hw/rtl/bmp_pixel_unpacker.sv
tb/bmp_pixel_unpacker_checker.sv
tb/bmp_pixel_unpacker_test.sv
